// File: rtl/assert_macros.svh
// Shared assertion macros for the slicer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked across reset
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: reset behavior");

`endif

// File: rtl/adc_hs_pkg.sv
package adc_hs_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 12;
  localparam int HYST_BITS   = 8;

  // Defaults for the top-level parameters
  localparam int BLOCK_LOG2_DEF     = 12;
  localparam int INITIAL_CENTER_DEF = 4020;

  // Hysteresis register value after reset
  localparam logic [HYST_BITS-1:0] HYST_RESET = HYST_BITS'(5);

  // One result beat
  typedef struct packed {
    logic                   level;
    logic [SAMPLE_BITS-1:0] center;
    logic                   block_end;
    logic [SAMPLE_BITS-1:0] block_min;
    logic [SAMPLE_BITS-1:0] block_max;
  } result_t;

endpackage

// File: rtl/adc_hs_core.sv
module adc_hs_core
  import adc_hs_pkg::*;
#(
  parameter int BLOCK_LOG2     = BLOCK_LOG2_DEF,
  parameter int INITIAL_CENTER = INITIAL_CENTER_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [HYST_BITS-1:0]   hysteresis,
  output result_t                result
);

  localparam int SUM_W = SAMPLE_BITS + BLOCK_LOG2;
  localparam int CMP_W = SAMPLE_BITS + 1;

  logic                   level_r,  level_nxt;
  logic [SAMPLE_BITS-1:0] center_r, center_nxt;
  logic [SUM_W-1:0]       sum_r,    sum_upd;
  logic [BLOCK_LOG2-1:0]  index_r;
  logic [SAMPLE_BITS-1:0] min_r,    min_upd;
  logic [SAMPLE_BITS-1:0] max_r,    max_upd;
  logic [CMP_W-1:0]       lhs, rhs;
  logic                   block_end;

  // Hysteresis compare: high level tests s + h > c, low level tests s > c + h
  always_comb begin
    if (level_r) begin
      lhs = CMP_W'(sample) + CMP_W'(hysteresis);
      rhs = CMP_W'(center_r);
    end else begin
      lhs = CMP_W'(sample);
      rhs = CMP_W'(center_r) + CMP_W'(hysteresis);
    end
    level_nxt = (lhs > rhs);
  end

  // Running statistics including this sample
  assign min_upd   = (sample < min_r) ? sample : min_r;
  assign max_upd   = (sample > max_r) ? sample : max_r;
  assign sum_upd   = sum_r + SUM_W'(sample);
  assign block_end = &index_r;

  // New center is the block mean, taken only at block end
  assign center_nxt = block_end ? sum_upd[BLOCK_LOG2 +: SAMPLE_BITS] : center_r;

  // Result beat
  always_comb begin
    result.level     = level_nxt;
    result.center    = center_nxt;
    result.block_end = block_end;
    result.block_min = block_end ? min_upd : '0;
    result.block_max = block_end ? max_upd : '0;
  end

  // State update per processed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= 1'b0;
      center_r <= SAMPLE_BITS'(INITIAL_CENTER);
      sum_r    <= '0;
      index_r  <= '0;
      min_r    <= '1;
      max_r    <= '0;
    end else if (step) begin
      level_r  <= level_nxt;
      center_r <= center_nxt;
      index_r  <= index_r + 1'b1;
      if (block_end) begin
        sum_r <= '0;
        min_r <= '1;
        max_r <= '0;
      end else begin
        sum_r <= sum_upd;
        min_r <= min_upd;
        max_r <= max_upd;
      end
    end
  end

endmodule

// File: rtl/adc_hysteresis_slicer.sv
// An input beat passes the input register, then the result register.
// Throughput: one sample per cycle unless out_ready stalls the output; the slice and
// the running-sum update share one combinational pass between the two registers.
// Reset (rst_n, synchronous, active low): both stages empty, hysteresis = 5,
// level 0, center = INITIAL_CENTER, block sum/count cleared, min all ones, max 0.
module adc_hysteresis_slicer
  import adc_hs_pkg::*;
#(
  parameter int BLOCK_LOG2     = BLOCK_LOG2_DEF,
  parameter int INITIAL_CENTER = INITIAL_CENTER_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [HYST_BITS-1:0]   cfg_data,
  // sample input
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  // result output
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_level,
  output logic [SAMPLE_BITS-1:0] out_center,
  output logic                   out_block_end,
  output logic [SAMPLE_BITS-1:0] out_block_min,
  output logic [SAMPLE_BITS-1:0] out_block_max
);

  logic [HYST_BITS-1:0]   hyst_r;
  logic                   in_valid_r;
  logic [SAMPLE_BITS-1:0] in_sample_r;
  logic                   out_valid_r;
  result_t                out_res_r;
  result_t                core_res;
  logic                   advance;

  // Hysteresis register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r <= HYST_RESET;
    end else if (cfg_valid) begin
      hyst_r <= cfg_data;
    end
  end

  // Move a beat from the input register to the result register
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_sample_r <= in_sample;
    end
  end

  adc_hs_core #(
    .BLOCK_LOG2     (BLOCK_LOG2),
    .INITIAL_CENTER (INITIAL_CENTER)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .sample     (in_sample_r),
    .hysteresis (hyst_r),
    .result     (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_level     = out_res_r.level;
  assign out_center    = out_res_r.center;
  assign out_block_end = out_res_r.block_end;
  assign out_block_min = out_res_r.block_min;
  assign out_block_max = out_res_r.block_max;

endmodule

// File: rtl/adc_hs_checker.sv
`include "assert_macros.svh"

module adc_hs_checker
  import adc_hs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_level,
  input logic [SAMPLE_BITS-1:0] out_center,
  input logic                   out_block_end,
  input logic [SAMPLE_BITS-1:0] out_block_min,
  input logic [SAMPLE_BITS-1:0] out_block_max
);

  result_t out_beat;
  logic    stats_clear;

  // Result payload as one word
  assign out_beat    = {out_level, out_center, out_block_end, out_block_min, out_block_max};
  assign stats_clear = (out_block_min == '0) && (out_block_max == '0);

  // A stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_beat))

  // Statistics are zero on beats that do not close a block
  `ASSERT_SAME(a_stats_zero, clk, rst_n, out_valid && !out_block_end, stats_clear)

  // A closed block's minimum never exceeds its maximum
  `ASSERT_SAME(a_min_le_max, clk, rst_n, out_valid && out_block_end, out_block_min <= out_block_max)

  // Result side is empty right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind adc_hysteresis_slicer adc_hs_checker u_adc_hs_checker (.*);
